// File: hdl/tszc_pkg.sv
`default_nettype none

package tszc_pkg;

   localparam int SAMPLE_W = 12;
   localparam int TORQUE_W = 16;
   localparam int KIND_W   = 2;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Divider: dividend holds deviation * full scale or a sample sum, divisor holds a span or a count
   localparam int DVD_W  = SAMPLE_W + TORQUE_W;
   localparam int DSR_W  = SAMPLE_W;
   localparam int STEP_W = $clog2(DVD_W);

   localparam int CAL_SAMPLES_DEF = 16;

   localparam logic [SAMPLE_W-1:0] VALID_LOW  = SAMPLE_W'(100);
   localparam logic [SAMPLE_W-1:0] VALID_HIGH = SAMPLE_W'(3995);

   localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ABORT   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd3;

   localparam logic [PHASE_W-1:0] PHASE_UNCAL    = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_CALIB    = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_CAL_OK   = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_FALLBACK = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_DEFAULT_ZERO = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEADBAND     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_LIMIT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FWD_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE   = 3'd4;

   typedef struct packed {
      logic load;       // capture the request word
      logic eval;       // update accumulators, form deviation and span
      logic mul;        // form deviation * full scale
      logic div_start;  // launch the divider
      logic div_mean;   // divider operands: sum / count instead of product / span
      logic commit;     // update phase and load the response word
   } cmd_type;

   typedef struct packed {
      logic finish;     // item closes the calibration
      logic mean_ok;    // enough valid samples for a mean
      logic scale;      // measure item needs the scaling divide
      logic div_done;
   } status_type;

endpackage

`default_nettype wire

// File: hdl/tszc_div.sv
`default_nettype none

module tszc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [tszc_pkg::DVD_W-1:0]  dividend,
   input  wire logic [tszc_pkg::DSR_W-1:0]  divisor,
   output logic                             done,
   output logic [tszc_pkg::DVD_W-1:0]       quotient
);

   localparam int DVD_W  = tszc_pkg::DVD_W;
   localparam int DSR_W  = tszc_pkg::DSR_W;
   localparam int STEP_W = tszc_pkg::STEP_W;

   logic [DSR_W-1:0]  rem_ff,  rem_in;
   logic [DVD_W-1:0]  quo_ff,  quo_in;
   logic [DSR_W-1:0]  dsr_ff,  dsr_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DSR_W:0] trial;
   logic [DSR_W:0] diff;
   logic           fits;

   // Restoring radix-2: one quotient bit per cycle, MSB first
   assign trial = {rem_ff, quo_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = busy_ff && (step_ff == '0);
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         step_in = STEP_W'(DVD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while still stepping");

endmodule

`default_nettype wire

// File: hdl/tszc_datapath.sv
`default_nettype none

module tszc_datapath #(
   parameter int CAL_SAMPLES = tszc_pkg::CAL_SAMPLES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [tszc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tszc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [tszc_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [tszc_pkg::SAMPLE_W-1:0]     req_sample,
   input  wire tszc_pkg::cmd_type                 cmd,
   output tszc_pkg::status_type                   status,
   output logic [tszc_pkg::TORQUE_W-1:0]          rsp_torque,
   output logic [tszc_pkg::SAMPLE_W-1:0]          rsp_zero_point,
   output logic [tszc_pkg::PHASE_W-1:0]           rsp_cal_state,
   output logic                                   rsp_sample_valid
);

   localparam int SAMPLE_W = tszc_pkg::SAMPLE_W;
   localparam int TORQUE_W = tszc_pkg::TORQUE_W;
   localparam int PHASE_W  = tszc_pkg::PHASE_W;
   localparam int KIND_W   = tszc_pkg::KIND_W;
   localparam int DVD_W    = tszc_pkg::DVD_W;
   localparam int DSR_W    = tszc_pkg::DSR_W;
   localparam int CNT_W    = $clog2(CAL_SAMPLES + 1);
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int HALF     = CAL_SAMPLES / 2;

   // configuration
   logic [SAMPLE_W-1:0] dflt_ff, dflt_in;
   logic [SAMPLE_W-1:0] dband_ff, dband_in;
   logic [SAMPLE_W-1:0] back_lim_ff, back_lim_in;
   logic [SAMPLE_W-1:0] fwd_lim_ff, fwd_lim_in;
   logic [TORQUE_W-1:0] fst_ff, fst_in;

   // calibration state
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [SUM_W-1:0]    vsum_ff, vsum_in;
   logic [CNT_W-1:0]    vcnt_ff, vcnt_in;
   logic [CNT_W-1:0]    taken_ff, taken_in;
   logic [SAMPLE_W-1:0] cal_zero_ff, cal_zero_in;

   // working registers
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                valid_ff, valid_in;
   logic [SAMPLE_W-1:0] dev_ff, dev_in;
   logic [DSR_W-1:0]    span_ff, span_in;
   logic                span_pos_ff, span_pos_in;
   logic [DVD_W-1:0]    prod_ff, prod_in;

   // response word
   logic [TORQUE_W-1:0] torque_ff, torque_in;
   logic [SAMPLE_W-1:0] zero_ff, zero_in;
   logic [PHASE_W-1:0]  cstate_ff, cstate_in;
   logic                sval_ff, sval_in;

   logic [SAMPLE_W-1:0] zero_use;
   logic [SAMPLE_W-1:0] dev;
   logic [SAMPLE_W:0]   back_span;
   logic [SAMPLE_W:0]   fwd_span;
   logic [SAMPLE_W:0]   span;
   logic                in_range;
   logic                finish;
   logic                mean_ok;
   logic                scale;
   logic [DVD_W-1:0]    div_dvd;
   logic [DSR_W-1:0]    div_dsr;
   logic                div_done;
   logic [DVD_W-1:0]    quot;
   logic [PHASE_W-1:0]  phase_new;
   logic [SAMPLE_W-1:0] cal_zero_new;
   logic [TORQUE_W-1:0] torque_new;

   assign zero_use  = (phase_ff == tszc_pkg::PHASE_CAL_OK) ? cal_zero_ff : dflt_ff;
   assign dev       = (sample_ff >= zero_use) ? (sample_ff - zero_use) : (zero_use - sample_ff);
   assign back_span = {1'b0, zero_use} - {1'b0, back_lim_ff};
   assign fwd_span  = {1'b0, fwd_lim_ff} - {1'b0, zero_use};
   assign span      = ($signed(back_span) > $signed(fwd_span)) ? back_span : fwd_span;
   assign in_range  = (sample_ff >= tszc_pkg::VALID_LOW) && (sample_ff <= tszc_pkg::VALID_HIGH);

   assign finish  = (phase_ff == tszc_pkg::PHASE_CALIB)
                    && (((kind_ff == tszc_pkg::KIND_SAMPLE) && (taken_ff >= CNT_W'(CAL_SAMPLES)))
                        || (kind_ff == tszc_pkg::KIND_ABORT));
   assign mean_ok = (vcnt_ff != '0) && (vcnt_ff >= CNT_W'(HALF));
   assign scale   = (kind_ff == tszc_pkg::KIND_MEASURE) && (dev_ff >= dband_ff) && span_pos_ff;

   assign div_dvd = cmd.div_mean ? DVD_W'(vsum_ff) : prod_ff;
   assign div_dsr = cmd.div_mean ? DSR_W'(vcnt_ff) : span_ff;

   tszc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      status.finish   = finish;
      status.mean_ok  = mean_ok;
      status.scale    = scale;
      status.div_done = div_done;
   end

   // outcome of the item, applied on commit
   always_comb begin
      phase_new    = phase_ff;
      cal_zero_new = cal_zero_ff;
      torque_new   = '0;
      if (kind_ff == tszc_pkg::KIND_START) begin
         phase_new = tszc_pkg::PHASE_CALIB;
      end else if (finish) begin
         if (mean_ok) begin
            cal_zero_new = quot[SAMPLE_W-1:0];
            phase_new    = tszc_pkg::PHASE_CAL_OK;
         end else begin
            phase_new = tszc_pkg::PHASE_FALLBACK;
         end
      end
      if (kind_ff == tszc_pkg::KIND_MEASURE) begin
         priority if (dev_ff < dband_ff) begin
            torque_new = '0;
         end else if (!span_pos_ff) begin
            torque_new = fst_ff;
         end else if (quot > DVD_W'(fst_ff)) begin
            torque_new = fst_ff;
         end else begin
            torque_new = quot[TORQUE_W-1:0];
         end
      end
   end

   always_comb begin
      dflt_in     = dflt_ff;
      dband_in    = dband_ff;
      back_lim_in = back_lim_ff;
      fwd_lim_in  = fwd_lim_ff;
      fst_in      = fst_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            tszc_pkg::REG_DEFAULT_ZERO: dflt_in     = csr_wdata[SAMPLE_W-1:0];
            tszc_pkg::REG_DEADBAND:     dband_in    = csr_wdata[SAMPLE_W-1:0];
            tszc_pkg::REG_BACK_LIMIT:   back_lim_in = csr_wdata[SAMPLE_W-1:0];
            tszc_pkg::REG_FWD_LIMIT:    fwd_lim_in  = csr_wdata[SAMPLE_W-1:0];
            tszc_pkg::REG_FULL_SCALE:   fst_in      = csr_wdata[TORQUE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      kind_in     = kind_ff;
      sample_in   = sample_ff;
      valid_in    = valid_ff;
      dev_in      = dev_ff;
      span_in     = span_ff;
      span_pos_in = span_pos_ff;
      prod_in     = prod_ff;
      vsum_in     = vsum_ff;
      vcnt_in     = vcnt_ff;
      taken_in    = taken_ff;
      phase_in    = phase_ff;
      cal_zero_in = cal_zero_ff;
      torque_in   = torque_ff;
      zero_in     = zero_ff;
      cstate_in   = cstate_ff;
      sval_in     = sval_ff;

      if (cmd.load) begin
         kind_in   = req_kind;
         sample_in = req_sample;
      end

      if (cmd.eval) begin
         valid_in    = 1'b0;
         dev_in      = dev;
         span_in     = span[DSR_W-1:0];
         span_pos_in = !span[SAMPLE_W] && (span[SAMPLE_W-1:0] != '0);
         if (kind_ff == tszc_pkg::KIND_START) begin
            vsum_in  = '0;
            vcnt_in  = '0;
            taken_in = '0;
         end else if ((kind_ff == tszc_pkg::KIND_SAMPLE)
                      && (phase_ff == tszc_pkg::PHASE_CALIB)) begin
            if (in_range) begin
               vsum_in  = vsum_ff + SUM_W'(sample_ff);
               vcnt_in  = vcnt_ff + CNT_W'(1);
               valid_in = 1'b1;
            end
            taken_in = taken_ff + CNT_W'(1);
         end
      end

      if (cmd.mul) begin
         prod_in = DVD_W'(dev_ff) * DVD_W'(fst_ff);
      end

      if (cmd.commit) begin
         phase_in    = phase_new;
         cal_zero_in = cal_zero_new;
         torque_in   = torque_new;
         zero_in     = (phase_new == tszc_pkg::PHASE_CAL_OK) ? cal_zero_new : dflt_ff;
         cstate_in   = phase_new;
         sval_in     = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff     <= SAMPLE_W'(2048);
         dband_ff    <= SAMPLE_W'(50);
         back_lim_ff <= '0;
         fwd_lim_ff  <= SAMPLE_W'(4095);
         fst_ff      <= TORQUE_W'(25600);
         phase_ff    <= tszc_pkg::PHASE_UNCAL;
         vsum_ff     <= '0;
         vcnt_ff     <= '0;
         taken_ff    <= '0;
         cal_zero_ff <= '0;
      end else begin
         dflt_ff     <= dflt_in;
         dband_ff    <= dband_in;
         back_lim_ff <= back_lim_in;
         fwd_lim_ff  <= fwd_lim_in;
         fst_ff      <= fst_in;
         phase_ff    <= phase_in;
         vsum_ff     <= vsum_in;
         vcnt_ff     <= vcnt_in;
         taken_ff    <= taken_in;
         cal_zero_ff <= cal_zero_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      sample_ff   <= sample_in;
      valid_ff    <= valid_in;
      dev_ff      <= dev_in;
      span_ff     <= span_in;
      span_pos_ff <= span_pos_in;
      prod_ff     <= prod_in;
      torque_ff   <= torque_in;
      zero_ff     <= zero_in;
      cstate_ff   <= cstate_in;
      sval_ff     <= sval_in;
   end

   assign rsp_torque       = torque_ff;
   assign rsp_zero_point   = zero_ff;
   assign rsp_cal_state    = cstate_ff;
   assign rsp_sample_valid = sval_ff;

   // a start clears the counters in any phase
   assert property (@(posedge clock) disable iff (reset)
                    ((phase_ff != tszc_pkg::PHASE_CALIB)
                     && !(cmd.eval && (kind_ff == tszc_pkg::KIND_START)))
                    |-> (taken_in == taken_ff))
      else $error("sample counted outside calibration");

   assert property (@(posedge clock) disable iff (reset)
                    vcnt_ff <= taken_ff)
      else $error("valid count exceeds taken count");

endmodule

`default_nettype wire

// File: hdl/tszc_ctrl.sv
`default_nettype none

module tszc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire tszc_pkg::status_type  status,
   output tszc_pkg::cmd_type          cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_MUL    = 3'd3;
   localparam logic [2:0] S_DIVGO  = 3'd4;
   localparam logic [2:0] S_DIV    = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // output register can take a new word when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            priority if (status.finish && status.mean_ok) begin
               cmd.div_start = 1'b1;
               cmd.div_mean  = 1'b1;
               state_in      = S_DIV;
            end else if (status.scale) begin
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIVGO;
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
                    cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("response word overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
                    status.div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

// File: hdl/torque_sensor_zero_cal_scaler.sv
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_kind, req_sample
// rsp       out        rsp_valid / rsp_ready   rsp_torque, rsp_zero_point,
//                                              rsp_cal_state, rsp_sample_valid
// csr       in         csr_wr_en               csr_index, csr_wdata
//
// One word at a time. Start, plain calibration samples, aborts that fall back, and
// measures inside the dead band or with no span go from eval and decide to commit;
// a closing calibration with a mean and a scaled measure (after a multiply) pass
// through the 28-step radix-2 divider. The next word is accepted once the response is
// loaded, even while it still waits on rsp_ready; a stalled rsp holds the item at commit.
// Synchronous reset restores the register defaults and clears calibration.
`default_nettype none

module torque_sensor_zero_cal_scaler #(
   parameter int CAL_SAMPLES = tszc_pkg::CAL_SAMPLES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [tszc_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [tszc_pkg::SAMPLE_W-1:0]     req_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [tszc_pkg::TORQUE_W-1:0]          rsp_torque,
   output logic [tszc_pkg::SAMPLE_W-1:0]          rsp_zero_point,
   output logic [tszc_pkg::PHASE_W-1:0]           rsp_cal_state,
   output logic                                   rsp_sample_valid,
   input  wire logic                              csr_wr_en,
   input  wire logic [tszc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tszc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tszc_pkg::cmd_type    cmd;
   tszc_pkg::status_type status;

   tszc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tszc_datapath #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_kind),
      .req_sample       (req_sample),
      .cmd              (cmd),
      .status           (status),
      .rsp_torque       (rsp_torque),
      .rsp_zero_point   (rsp_zero_point),
      .rsp_cal_state    (rsp_cal_state),
      .rsp_sample_valid (rsp_sample_valid)
   );

endmodule

`default_nettype wire

// File: dv/torque_scaler_checker.sv
`default_nettype none

module torque_scaler_checker
   import tszc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_ready,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [SAMPLE_W-1:0]   req_sample,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic [TORQUE_W-1:0]   rsp_torque,
   input  wire logic [SAMPLE_W-1:0]   rsp_zero_point,
   input  wire logic [PHASE_W-1:0]    rsp_cal_state,
   input  wire logic                  rsp_sample_valid,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                mismatches,
   output int unsigned                outstanding
);

   localparam int CAL_WORDS = CAL_SAMPLES_DEF;

   typedef struct packed {
      logic [TORQUE_W-1:0] torque;
      logic [SAMPLE_W-1:0] zero_point;
      logic [PHASE_W-1:0]  cal_state;
      logic                sample_valid;
   } torque_word_t;

   torque_word_t expected_words[$];

   logic [SAMPLE_W-1:0] dflt_zero;
   logic [SAMPLE_W-1:0] deadband;
   logic [SAMPLE_W-1:0] back_limit;
   logic [SAMPLE_W-1:0] fwd_limit;
   logic [TORQUE_W-1:0] full_scale;

   logic [19:0]         sum_acc;
   logic [8:0]          valid_cnt;
   logic [8:0]          taken_cnt;
   logic [SAMPLE_W-1:0] cal_zero;
   logic [PHASE_W-1:0]  cal_phase;

   function automatic logic [SAMPLE_W-1:0] zero_in_force();
      return (cal_phase == PHASE_CAL_OK) ? cal_zero : dflt_zero;
   endfunction

   function automatic void close_calibration();
      if (valid_cnt != 0 && valid_cnt >= CAL_WORDS / 2) begin
         cal_zero  = SAMPLE_W'(sum_acc / valid_cnt);
         cal_phase = PHASE_CAL_OK;
      end else begin
         cal_phase = PHASE_FALLBACK;
      end
   endfunction

   function automatic logic [TORQUE_W-1:0] scaled_torque(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] z;
      logic [SAMPLE_W-1:0] dev;
      int                  span;
      longint unsigned     quot;
      z    = zero_in_force();
      dev  = (s >= z) ? s - z : z - s;
      // larger of the spans toward either limit; may be zero or negative
      span = int'(z) - int'(back_limit);
      if (int'(fwd_limit) - int'(z) > span) span = int'(fwd_limit) - int'(z);
      if (dev < deadband) return '0;
      if (span <= 0) return full_scale;
      quot = (longint'(dev) * longint'(full_scale)) / longint'(span);
      return (quot > full_scale) ? full_scale : quot[TORQUE_W-1:0];
   endfunction

   function automatic torque_word_t predict_word(input logic [KIND_W-1:0]   kind,
                                                 input logic [SAMPLE_W-1:0] s);
      torque_word_t w;
      w = '0;
      case (kind)
         KIND_START: begin
            sum_acc   = '0;
            valid_cnt = '0;
            taken_cnt = '0;
            cal_phase = PHASE_CALIB;
         end
         KIND_SAMPLE: begin
            // drop samples that arrive outside calibration
            if (cal_phase == PHASE_CALIB) begin
               if (s >= VALID_LOW && s <= VALID_HIGH) begin
                  sum_acc        = sum_acc + 20'(s);
                  valid_cnt      = valid_cnt + 1'b1;
                  w.sample_valid = 1'b1;
               end
               taken_cnt = taken_cnt + 1'b1;
               if (taken_cnt >= CAL_WORDS) close_calibration();
            end
         end
         KIND_ABORT: begin
            if (cal_phase == PHASE_CALIB) close_calibration();
         end
         KIND_MEASURE: begin
            w.torque = scaled_torque(s);
         end
         default: ;
      endcase
      w.zero_point = zero_in_force();
      w.cal_state  = cal_phase;
      return w;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t rsp_%s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      torque_word_t want;
      if (reset) begin
         dflt_zero   = 12'd2048;
         deadband    = 12'd50;
         back_limit  = '0;
         fwd_limit   = '1;
         full_scale  = 16'd25600;
         sum_acc     = '0;
         valid_cnt   = '0;
         taken_cnt   = '0;
         cal_zero    = '0;
         cal_phase   = PHASE_UNCAL;
         mismatches  = 0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_DEFAULT_ZERO: dflt_zero  = csr_wdata[SAMPLE_W-1:0];
               REG_DEADBAND:     deadband   = csr_wdata[SAMPLE_W-1:0];
               REG_BACK_LIMIT:   back_limit = csr_wdata[SAMPLE_W-1:0];
               REG_FWD_LIMIT:    fwd_limit  = csr_wdata[SAMPLE_W-1:0];
               REG_FULL_SCALE:   full_scale = csr_wdata[TORQUE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               mismatches++;
               $display("%0t rsp word with none expected: actual torque %0d zero_point %0d",
                        $time, rsp_torque, rsp_zero_point);
            end else begin
               want = expected_words.pop_front();
               check_field("torque", 32'(want.torque), 32'(rsp_torque));
               check_field("zero_point", 32'(want.zero_point), 32'(rsp_zero_point));
               check_field("cal_state", 32'(want.cal_state), 32'(rsp_cal_state));
               check_field("sample_valid", 32'(want.sample_valid), 32'(rsp_sample_valid));
            end
         end
         if (req_valid && req_ready) expected_words.push_back(predict_word(req_kind, req_sample));
      end
      outstanding = expected_words.size();
   end

endmodule

`default_nettype wire

// File: dv/tb_torque_sensor_zero_cal_scaler.sv
`default_nettype none

module tb_torque_sensor_zero_cal_scaler;
   import tszc_pkg::*;

   localparam int RANDOM_WORDS = 700;
   localparam int PHASE_COUNT  = 7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 35;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_kind   = KIND_START;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready  = 1'b0;
   logic [TORQUE_W-1:0]   rsp_torque;
   logic [SAMPLE_W-1:0]   rsp_zero_point;
   logic [PHASE_W-1:0]    rsp_cal_state;
   logic                  rsp_sample_valid;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = REG_DEFAULT_ZERO;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned words_sent   = 0;
   int unsigned req_idle_pct = IDLE_PCT;
   int unsigned rsp_idle_pct = IDLE_PCT;
   int unsigned cycle_count  = 0;
   int          last_center  = 2048;

   torque_sensor_zero_cal_scaler uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_torque       (rsp_torque),
      .rsp_zero_point   (rsp_zero_point),
      .rsp_cal_state    (rsp_cal_state),
      .rsp_sample_valid (rsp_sample_valid),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   torque_scaler_checker word_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_torque       (rsp_torque),
      .rsp_zero_point   (rsp_zero_point),
      .rsp_cal_state    (rsp_cal_state),
      .rsp_sample_valid (rsp_sample_valid),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_torque_sensor_zero_cal_scaler NOT OK");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off so the block backs up
   initial begin : rsp_side
      int unsigned taken;
      int unsigned hold_left;
      bit          held;
      taken     = 0;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) taken++;
         if (!held && taken >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v, input int lo, input int hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return SAMPLE_W'(v);
   endfunction

   // hold valid and payload until the word is taken; valid stays high on return
   task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SAMPLE_W-1:0] sample);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_sample <= sample;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic load_settings(input logic [SAMPLE_W-1:0] zero, input logic [SAMPLE_W-1:0] dead,
                                input logic [SAMPLE_W-1:0] back, input logic [SAMPLE_W-1:0] fwd,
                                input logic [TORQUE_W-1:0] scale);
      logic [CSR_IDX_W-1:0]  idx  [5];
      logic [CSR_DATA_W-1:0] data [5];
      idx[0] = REG_DEFAULT_ZERO;  data[0] = CSR_DATA_W'(zero);
      idx[1] = REG_DEADBAND;      data[1] = CSR_DATA_W'(dead);
      idx[2] = REG_BACK_LIMIT;    data[2] = CSR_DATA_W'(back);
      idx[3] = REG_FWD_LIMIT;     data[3] = CSR_DATA_W'(fwd);
      idx[4] = REG_FULL_SCALE;    data[4] = CSR_DATA_W'(scale);
      for (int i = 0; i < 5; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [SAMPLE_W-1:0] stray_sample();
      if ($urandom_range(1) == 0) return SAMPLE_W'($urandom_range(int'(VALID_LOW) - 1));
      return SAMPLE_W'($urandom_range(int'(SAMPLE_MAX), int'(VALID_HIGH) + 1));
   endfunction

   // start, a run of samples clustered around a random rest point, sometimes cut short
   task automatic calibration_run();
      int          center;
      int          spread;
      int unsigned miss_pct;
      int unsigned count;
      bit          cut_short;
      center      = int'($urandom_range(VALID_HIGH, VALID_LOW));
      spread      = int'($urandom_range(60));
      miss_pct    = ($urandom_range(3) == 0) ? $urandom_range(80) : $urandom_range(15);
      cut_short   = ($urandom_range(5) == 0);
      count       = cut_short ? $urandom_range(CAL_SAMPLES_DEF - 1) : CAL_SAMPLES_DEF;
      last_center = center;
      send_word(KIND_START, SAMPLE_W'($urandom));
      for (int i = 0; i < int'(count); i++) begin
         if ($urandom_range(19) == 0) send_word(KIND_MEASURE, SAMPLE_W'($urandom));
         if ($urandom_range(99) < miss_pct) begin
            send_word(KIND_SAMPLE, stray_sample());
         end else begin
            send_word(KIND_SAMPLE, clamp_sample(center + int'($urandom_range(2 * spread)) - spread,
                                                int'(VALID_LOW), int'(VALID_HIGH)));
         end
      end
      if (cut_short && $urandom_range(3) != 0) send_word(KIND_ABORT, SAMPLE_W'($urandom));
   endtask

   task automatic measure_burst();
      int unsigned n;
      logic [SAMPLE_W-1:0] s;
      n = $urandom_range(12, 4);
      repeat (n) begin
         case ($urandom_range(3))
            0, 1: s = SAMPLE_W'($urandom);
            2: s = clamp_sample(last_center + int'($urandom_range(600)) - 300,
                                0, int'(SAMPLE_MAX));
            default: begin
               case ($urandom_range(2))
                  0: s = '0;
                  1: s = SAMPLE_MAX;
                  default: s = SAMPLE_W'(last_center);
               endcase
            end
         endcase
         send_word(KIND_MEASURE, s);
      end
   endtask

   initial begin : stimulus
      int unsigned phase_end;
      int unsigned pick;
      logic [SAMPLE_W-1:0] z;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: rest point 2048, dead band 50, full span
      send_word(KIND_MEASURE, '0);
      send_word(KIND_MEASURE, SAMPLE_MAX);
      send_word(KIND_MEASURE, 12'd2048);
      send_word(KIND_MEASURE, 12'd2097);
      send_word(KIND_MEASURE, 12'd2098);
      send_word(KIND_SAMPLE, 12'd2000);
      send_word(KIND_ABORT, '0);
      send_word(KIND_START, '0);
      send_word(KIND_ABORT, SAMPLE_MAX);
      send_word(KIND_START, SAMPLE_MAX);
      send_word(KIND_SAMPLE, VALID_LOW - 1'b1);
      send_word(KIND_SAMPLE, VALID_LOW);
      send_word(KIND_SAMPLE, VALID_HIGH);
      send_word(KIND_SAMPLE, VALID_HIGH + 1'b1);
      send_word(KIND_MEASURE, SAMPLE_MAX);
      send_word(KIND_START, '0);
      send_word(KIND_SAMPLE, '0);
      send_word(KIND_SAMPLE, SAMPLE_MAX);
      send_word(KIND_ABORT, '0);
      send_word(KIND_MEASURE, '0);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         case (p)
            0: load_settings('0, '0, '0, SAMPLE_MAX, '1);
            1: load_settings(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0, '0);
            3: begin
               // no span at all: anything outside the dead band saturates
               z = SAMPLE_W'($urandom);
               load_settings(z, SAMPLE_W'($urandom_range(40)), z, z, TORQUE_W'($urandom));
            end
            4: load_settings(SAMPLE_W'($urandom_range(2200, 1900)), SAMPLE_W'($urandom_range(80)),
                             SAMPLE_W'($urandom_range(300)),
                             SAMPLE_W'($urandom_range(int'(SAMPLE_MAX), 3800)),
                             TORQUE_W'($urandom));
            default: load_settings(SAMPLE_W'($urandom),
                                   ($urandom_range(1) == 0) ? SAMPLE_W'($urandom)
                                                            : SAMPLE_W'($urandom_range(100)),
                                   SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                                   TORQUE_W'($urandom));
         endcase
         // one phase runs flat out on both sides; the long rsp hold lands in it
         req_idle_pct = (p == 2) ? 0 : IDLE_PCT;
         rsp_idle_pct = (p == 2) ? 0 : IDLE_PCT;
         phase_end    = words_sent + RANDOM_WORDS / PHASE_COUNT;
         while (words_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               calibration_run();
            end else if (pick < 85) begin
               measure_burst();
            end else begin
               send_word(KIND_W'($urandom), SAMPLE_W'($urandom));
            end
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_torque_sensor_zero_cal_scaler OK");
      end else begin
         $display("tb_torque_sensor_zero_cal_scaler NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hdl/tszc_pkg.sv
hdl/tszc_div.sv
hdl/tszc_datapath.sv
hdl/tszc_ctrl.sv
hdl/torque_sensor_zero_cal_scaler.sv
dv/torque_scaler_checker.sv
dv/tb_torque_sensor_zero_cal_scaler.sv
